@@ design/prs_pkg.sv @@
// Shared types, codes and constants of the power and reset sequencer.
// Used by every module of the sequencer; depends on nothing.
package prs_pkg;

    localparam int CFG_W              = 20;
    localparam int REG_IDX_W          = 2;
    localparam int TIMER_BITS_DEFAULT = 20;

    localparam logic [CFG_W-1:0] RESET_TICKS_DEFAULT    = CFG_W'(100000);
    localparam logic [CFG_W-1:0] NMI_TICKS_DEFAULT      = CFG_W'(1000);
    localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_DEFAULT = CFG_W'(10000);

    localparam logic [REG_IDX_W-1:0] REG_RESET_TICKS    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NMI_TICKS      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd2;

    localparam logic [2:0] CMD_POWER_ON    = 3'd1;
    localparam logic [2:0] CMD_POWER_OFF   = 3'd2;
    localparam logic [2:0] CMD_RESET_PULSE = 3'd3;
    localparam logic [2:0] CMD_NMI         = 3'd4;
    localparam logic [2:0] CMD_QUERY       = 3'd5;

    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_IDLE     = 4'd1,
        PH_PG_WAIT  = 4'd2,
        PH_RST_HOLD = 4'd3,
        PH_NMI      = 4'd4,
        PH_DEB1     = 4'd5,
        PH_WAIT_REL = 4'd6,
        PH_DEB2     = 4'd7,
        PH_RST_TAIL = 4'd8,
        PH_PG_LOST  = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        BUTTON_NONE  = 2'd0,
        BUTTON_POWER = 2'd1,
        BUTTON_RESET = 2'd2,
        BUTTON_DEBUG = 2'd3
    } btn_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_ticks;
        logic [CFG_W-1:0] nmi_ticks;
        logic [CFG_W-1:0] debounce_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       power_good;
        logic       reset_line_low;
        logic       power_button;
        logic       reset_button;
        logic       debug_button;
    } item_t;

    typedef struct packed {
        phase_t phase;
        logic   supply_is_on;
        btn_t   pending;
    } state_t;

    typedef struct packed {
        logic supply_on;
        logic reset_drive;
        logic nmi_drive;
        logic busy_res;
        logic reply_valid;
        logic power_state;
    } result_t;

endpackage

@@ design/prs_cfg_regs.sv @@
// Configuration registers of the power and reset sequencer.
// Depends on prs_pkg for the register indexes, defaults and cfg_t.
module prs_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          write_en,
    input  logic [prs_pkg::REG_IDX_W-1:0] write_index,
    input  logic [prs_pkg::CFG_W-1:0]     write_data,
    output prs_pkg::cfg_t                 cfg
);
    import prs_pkg::*;

    cfg_t cfg_reg;

    // Writes to an index past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_ticks    <= RESET_TICKS_DEFAULT;
            cfg_reg.nmi_ticks      <= NMI_TICKS_DEFAULT;
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_DEFAULT;
        end
        else if (write_en)
        begin
            if (write_index == REG_RESET_TICKS)
                cfg_reg.reset_ticks <= write_data;
            else if (write_index == REG_NMI_TICKS)
                cfg_reg.nmi_ticks <= write_data;
            else if (write_index == REG_DEBOUNCE_TICKS)
                cfg_reg.debounce_ticks <= write_data;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/prs_step.sv @@
// Next-state and pin-drive logic for one timer tick of the sequencer.
// Purely combinational; depends on prs_pkg for the phase, button and command codes.
module prs_step #(
    parameter int TIMER_BITS = prs_pkg::TIMER_BITS_DEFAULT
)
(
    input  prs_pkg::cfg_t          cfg,
    input  prs_pkg::item_t         item,
    input  prs_pkg::state_t        state,
    input  logic [TIMER_BITS-1:0]  timer,
    output prs_pkg::state_t        state_next,
    output logic [TIMER_BITS-1:0]  timer_next,
    output prs_pkg::result_t       result
);
    import prs_pkg::*;

    localparam int LW = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;

    logic [CFG_W-1:0] tail_len;
    logic [CFG_W-1:0] len_sel;
    logic [LW-1:0]    len_min;
    logic [LW-1:0]    len_eff;
    logic [LW-1:0]    limit;
    logic [LW-1:0]    timer_inc;
    logic             done;
    logic [TIMER_BITS-1:0] timer_step;
    logic             held;
    logic             reply;
    logic             rd;

    // Only one timed phase runs at a time, so one length mux and one compare serve all.
    assign tail_len = (cfg.reset_ticks > cfg.debounce_ticks) ?
                      (cfg.reset_ticks - cfg.debounce_ticks) : CFG_W'(1);

    always_comb
    begin
        unique case (state.phase)
            PH_NMI:                len_sel = cfg.nmi_ticks;
            PH_DEB1, PH_DEB2:      len_sel = cfg.debounce_ticks;
            PH_RST_TAIL:           len_sel = tail_len;
            default:               len_sel = cfg.reset_ticks;
        endcase
    end

    assign limit     = LW'(1) << TIMER_BITS;
    assign len_min   = (len_sel == '0) ? LW'(1) : LW'(len_sel);
    assign len_eff   = (len_min > limit) ? limit : len_min;
    assign timer_inc = LW'(timer) + LW'(1);
    assign done      = (timer_inc >= len_eff);
    assign timer_step = done ? '0 : timer_inc[TIMER_BITS-1:0];

    always_comb
    begin
        unique case (state.pending)
            BUTTON_POWER: held = item.power_button;
            BUTTON_RESET: held = item.reset_button;
            BUTTON_DEBUG: held = item.debug_button;
            default:      held = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state;
        timer_next = timer;
        reply      = 1'b0;
        unique case (state.phase)
            PH_START:
            begin
                timer_next = timer_step;
                if (done)
                    state_next.phase = PH_IDLE;
            end
            PH_IDLE:
            begin
                priority if (item.cmd == CMD_POWER_ON)
                begin
                    if (!state.supply_is_on)
                    begin
                        state_next.supply_is_on = 1'b1;
                        state_next.pending      = BUTTON_NONE;
                        state_next.phase        = PH_PG_WAIT;
                        timer_next              = '0;
                    end
                end
                else if (item.cmd == CMD_POWER_OFF)
                    state_next.supply_is_on = 1'b0;
                else if (item.cmd == CMD_RESET_PULSE)
                begin
                    state_next.pending = BUTTON_NONE;
                    state_next.phase   = PH_RST_HOLD;
                    timer_next         = '0;
                end
                else if (item.cmd == CMD_NMI)
                begin
                    state_next.pending = BUTTON_NONE;
                    state_next.phase   = PH_NMI;
                    timer_next         = '0;
                end
                else if (item.cmd == CMD_QUERY)
                    reply = 1'b1;
                else if (item.reset_line_low && state.supply_is_on)
                begin
                    state_next.pending = BUTTON_NONE;
                    state_next.phase   = PH_RST_HOLD;
                    timer_next         = '0;
                end
                else if (item.power_button)
                begin
                    state_next.pending      = BUTTON_POWER;
                    state_next.supply_is_on = !state.supply_is_on;
                    state_next.phase        = state.supply_is_on ? PH_DEB1 : PH_PG_WAIT;
                    timer_next              = '0;
                end
                else if (item.reset_button)
                begin
                    state_next.pending = BUTTON_RESET;
                    state_next.phase   = PH_DEB1;
                    timer_next         = '0;
                end
                else if (item.debug_button)
                begin
                    state_next.pending = BUTTON_DEBUG;
                    state_next.phase   = PH_NMI;
                    timer_next         = '0;
                end
                else if (!item.power_good && state.supply_is_on)
                begin
                    state_next.pending = BUTTON_NONE;
                    state_next.phase   = PH_PG_LOST;
                    timer_next         = '0;
                end
                else
                    // No event on this tick: the sequencer stays idle.
                    state_next.phase = PH_IDLE;
            end
            PH_PG_WAIT, PH_PG_LOST:
            begin
                if (item.power_good)
                begin
                    state_next.phase = PH_RST_HOLD;
                    timer_next       = '0;
                end
            end
            PH_RST_HOLD, PH_NMI:
            begin
                timer_next = timer_step;
                if (done)
                begin
                    // A button that started this pulse still has to be released.
                    if ((state.phase == PH_RST_HOLD && state.pending == BUTTON_POWER) ||
                        (state.phase == PH_NMI && state.pending == BUTTON_DEBUG))
                        state_next.phase = PH_DEB1;
                    else
                    begin
                        state_next.pending = BUTTON_NONE;
                        state_next.phase   = PH_IDLE;
                    end
                end
            end
            PH_DEB1:
            begin
                timer_next = timer_step;
                if (done)
                    state_next.phase = PH_WAIT_REL;
            end
            PH_WAIT_REL:
            begin
                if (!held)
                begin
                    state_next.phase = (state.pending == BUTTON_RESET) ? PH_RST_TAIL : PH_DEB2;
                    timer_next       = '0;
                end
            end
            PH_DEB2, PH_RST_TAIL:
            begin
                timer_next = timer_step;
                if (done)
                begin
                    state_next.pending = BUTTON_NONE;
                    state_next.phase   = PH_IDLE;
                end
            end
            default:
            begin
                state_next.pending = BUTTON_NONE;
                state_next.phase   = PH_IDLE;
                timer_next         = '0;
            end
        endcase
    end

    // Pin drives reflect the state after this tick's update.
    assign rd = (state_next.phase == PH_START) || (state_next.phase == PH_PG_WAIT) ||
                (state_next.phase == PH_RST_HOLD) || (state_next.phase == PH_PG_LOST) ||
                (state_next.phase == PH_RST_TAIL) ||
                (((state_next.phase == PH_DEB1) || (state_next.phase == PH_WAIT_REL)) &&
                 (state_next.pending == BUTTON_RESET));

    assign result.supply_on   = state_next.supply_is_on;
    assign result.reset_drive = rd;
    assign result.nmi_drive   = (state_next.phase == PH_NMI);
    assign result.busy_res    = (state_next.phase != PH_IDLE);
    assign result.reply_valid = reply;
    assign result.power_state = reply & state_next.supply_is_on;

endmodule

@@ design/power_reset_sequencer_core.sv @@
// Power and reset sequencer: each accepted beat is one timer tick, each tick returns one result.
// A tick beat is held in the input register, and its result then in the result register.
// Throughput: one tick beat per cycle while out_ready holds, set by the combinational tick
// update between the input register and the result register; the result register frees the input side.
// Reset: the sequencer starts in the start-up phase holding reset for reset_ticks ticks,
// with the supply off and the configuration registers at their default values.
module power_reset_sequencer_core #(
    parameter int TIMER_BITS = prs_pkg::TIMER_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          write_en,
    input  logic [prs_pkg::REG_IDX_W-1:0] write_index,
    input  logic [prs_pkg::CFG_W-1:0]     write_data,
    // Tick channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    cmd,
    input  logic                          power_good,
    input  logic                          reset_line_low,
    input  logic                          power_button,
    input  logic                          reset_button,
    input  logic                          debug_button,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          supply_on,
    output logic                          reset_drive,
    output logic                          nmi_drive,
    output logic                          busy_res,
    output logic                          reply_valid,
    output logic                          power_state
);
    import prs_pkg::*;

    cfg_t    cfg;

    // Input register: holds the accepted tick until the result register can take it.
    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   item_reg;

    // Sequencer state.
    state_t  state_reg;
    state_t  state_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;

    // Result register.
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;

    logic    in_fire;
    logic    advance;

    prs_cfg_regs u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .cfg         (cfg)
    );

    prs_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step
    (
        .cfg        (cfg),
        .item       (item_reg),
        .state      (state_reg),
        .timer      (timer_reg),
        .state_next (state_next),
        .timer_next (timer_next),
        .result     (result_next)
    );

    // The held tick moves on whenever the result register is empty or being drained,
    // so a new tick is taken in the same cycle and the state updates once per tick.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign in_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.phase        <= PH_START;
            state_reg.supply_is_on <= 1'b0;
            state_reg.pending      <= BUTTON_NONE;
            timer_reg              <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
                timer_reg <= timer_next;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.cmd            <= cmd;
            item_reg.power_good     <= power_good;
            item_reg.reset_line_low <= reset_line_low;
            item_reg.power_button   <= power_button;
            item_reg.reset_button   <= reset_button;
            item_reg.debug_button   <= debug_button;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign supply_on   = result_reg.supply_on;
    assign reset_drive = result_reg.reset_drive;
    assign nmi_drive   = result_reg.nmi_drive;
    assign busy_res    = result_reg.busy_res;
    assign reply_valid = result_reg.reply_valid;
    assign power_state = result_reg.power_state;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for power_reset_sequencer_core: tick beats in, pin-state beats out.
// Depends on prs_pkg and the RTL of the core only; it predicts every result beat itself.

module testbench;

    import prs_pkg::*;

    // ------------------------------------------------------------------------------------
    // Constants of the bench.
    // ------------------------------------------------------------------------------------
    localparam int TIMER_BITS    = TIMER_BITS_DEFAULT;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES  = 6;     // wait after the last result beat has come back
    localparam int IDLE_PERCENT  = 16;
    localparam int STARTUP_TICKS = 120;

    localparam logic [2:0]           CMD_NONE      = 3'd0;
    localparam logic [2:0]           CMD_SPARE_LO  = 3'd6;
    localparam logic [2:0]           CMD_SPARE_HI  = 3'd7;
    localparam logic [REG_IDX_W-1:0] REG_SPARE     = 2'd3;
    localparam logic [CFG_W-1:0]     LEN_MAX       = {CFG_W{1'b1}};

    // ------------------------------------------------------------------------------------
    // Signals of the block.
    // ------------------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 write_en;
    logic [REG_IDX_W-1:0] write_index;
    logic [CFG_W-1:0]     write_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [2:0]           cmd;
    logic                 power_good;
    logic                 reset_line_low;
    logic                 power_button;
    logic                 reset_button;
    logic                 debug_button;
    logic                 out_valid;
    logic                 out_ready;
    logic                 supply_on;
    logic                 reset_drive;
    logic                 nmi_drive;
    logic                 busy_res;
    logic                 reply_valid;
    logic                 power_state;

    power_reset_sequencer_core #(
        .TIMER_BITS(TIMER_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .write_en      (write_en),
        .write_index   (write_index),
        .write_data    (write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .power_good    (power_good),
        .reset_line_low(reset_line_low),
        .power_button  (power_button),
        .reset_button  (reset_button),
        .debug_button  (debug_button),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .supply_on     (supply_on),
        .reset_drive   (reset_drive),
        .nmi_drive     (nmi_drive),
        .busy_res      (busy_res),
        .reply_valid   (reply_valid),
        .power_state   (power_state)
    );

    // ------------------------------------------------------------------------------------
    // Bench state: the predicted sequencer, pending pin states and run statistics.
    // ------------------------------------------------------------------------------------
    // Our own copy of the three length registers, as the block should hold them.
    logic [CFG_W-1:0] reg_reset_len;
    logic [CFG_W-1:0] reg_nmi_len;
    logic [CFG_W-1:0] reg_debounce_len;

    // Predicted sequencer state.
    phase_t    seq_phase;
    bit [32:0] seq_timer;
    logic      seq_supply;
    btn_t      seq_pending;

    // Pin states we expect, oldest first, one per accepted tick beat.
    result_t   pins_due[$];

    // Levels of the buttons and of power-good in random traffic. They persist from tick to
    // tick so that presses are held and released the way a person would do it.
    logic held_power;
    logic held_reset;
    logic held_debug;
    logic pg_level;

    // Handshake pacing knobs.
    bit send_idles;
    bit recv_idles;
    int hold_off_left;

    int cycle_count;
    int mismatch_count;
    int ticks_sent;
    int pins_checked;
    int queries_seen;
    int settings_used;
    int input_stall_cycles;

    // ------------------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The watchdog ends a run that hangs, for instance when a beat never gets accepted.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles with %0d beats pending.",
                     cycle_count, pins_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Predictor of the sequencer.
    // ------------------------------------------------------------------------------------
    // A register value of zero acts as one, and nothing runs longer than the timer can count.
    function automatic bit [32:0] phase_len(input bit [32:0] n);
        bit [32:0] top;
        top = 33'd1 << TIMER_BITS;
        if (n == 0)
            return 33'd1;
        if (n > top)
            return top;
        return n;
    endfunction

    // Advances the phase timer; true on the last tick of a phase of length n.
    function automatic bit timer_expired(input bit [32:0] n);
        if (seq_timer + 1 >= phase_len(n))
        begin
            seq_timer = '0;
            return 1'b1;
        end
        seq_timer = (seq_timer + 1) & ((33'd1 << TIMER_BITS) - 1);
        return 1'b0;
    endfunction

    function automatic void go_to(input phase_t next_phase);
        seq_phase = next_phase;
        seq_timer = '0;
    endfunction

    // Applies one tick to the predicted state and returns the pin states it should produce.
    function automatic result_t predict_pins(input item_t t);
        result_t   pins;
        logic      held;
        logic      answered;
        bit [32:0] tail_len;
        answered = 1'b0;
        held     = 1'b0;
        case (seq_phase)
            PH_START:
            begin
                if (timer_expired(33'(reg_reset_len)))
                    go_to(PH_IDLE);
            end
            PH_IDLE:
            begin
                // A bus command takes the whole tick; pins wait for a later one.
                if (t.cmd >= CMD_POWER_ON && t.cmd <= CMD_QUERY)
                begin
                    case (t.cmd)
                        CMD_POWER_ON:
                        begin
                            if (!seq_supply)
                            begin
                                seq_supply  = 1'b1;
                                seq_pending = BUTTON_NONE;
                                go_to(PH_PG_WAIT);
                            end
                        end
                        CMD_POWER_OFF:
                        begin
                            seq_supply = 1'b0;
                        end
                        CMD_RESET_PULSE:
                        begin
                            seq_pending = BUTTON_NONE;
                            go_to(PH_RST_HOLD);
                        end
                        CMD_NMI:
                        begin
                            seq_pending = BUTTON_NONE;
                            go_to(PH_NMI);
                        end
                        default:
                        begin
                            answered = 1'b1;
                        end
                    endcase
                end
                else if (t.reset_line_low && seq_supply)
                begin
                    seq_pending = BUTTON_NONE;
                    go_to(PH_RST_HOLD);
                end
                else if (t.power_button)
                begin
                    seq_pending = BUTTON_POWER;
                    if (seq_supply)
                    begin
                        seq_supply = 1'b0;
                        go_to(PH_DEB1);
                    end
                    else
                    begin
                        seq_supply = 1'b1;
                        go_to(PH_PG_WAIT);
                    end
                end
                else if (t.reset_button)
                begin
                    seq_pending = BUTTON_RESET;
                    go_to(PH_DEB1);
                end
                else if (t.debug_button)
                begin
                    seq_pending = BUTTON_DEBUG;
                    go_to(PH_NMI);
                end
                else if (!t.power_good && seq_supply)
                begin
                    seq_pending = BUTTON_NONE;
                    go_to(PH_PG_LOST);
                end
            end
            PH_PG_WAIT, PH_PG_LOST:
            begin
                if (t.power_good)
                    go_to(PH_RST_HOLD);
            end
            PH_RST_HOLD:
            begin
                if (timer_expired(33'(reg_reset_len)))
                begin
                    if (seq_pending == BUTTON_POWER)
                        go_to(PH_DEB1);
                    else
                    begin
                        seq_pending = BUTTON_NONE;
                        go_to(PH_IDLE);
                    end
                end
            end
            PH_NMI:
            begin
                if (timer_expired(33'(reg_nmi_len)))
                begin
                    if (seq_pending == BUTTON_DEBUG)
                        go_to(PH_DEB1);
                    else
                    begin
                        seq_pending = BUTTON_NONE;
                        go_to(PH_IDLE);
                    end
                end
            end
            PH_DEB1:
            begin
                if (timer_expired(33'(reg_debounce_len)))
                    go_to(PH_WAIT_REL);
            end
            PH_WAIT_REL:
            begin
                case (seq_pending)
                    BUTTON_POWER: held = t.power_button;
                    BUTTON_RESET: held = t.reset_button;
                    BUTTON_DEBUG: held = t.debug_button;
                    default:      held = 1'b0;
                endcase
                if (!held)
                begin
                    if (seq_pending == BUTTON_RESET)
                        go_to(PH_RST_TAIL);
                    else
                        go_to(PH_DEB2);
                end
            end
            PH_DEB2:
            begin
                if (timer_expired(33'(reg_debounce_len)))
                begin
                    seq_pending = BUTTON_NONE;
                    go_to(PH_IDLE);
                end
            end
            PH_RST_TAIL:
            begin
                // After a reset button release the line stays low for what is left of the
                // reset time, but never for less than one tick.
                if (reg_reset_len > reg_debounce_len)
                    tail_len = 33'(reg_reset_len - reg_debounce_len);
                else
                    tail_len = 33'd1;
                if (timer_expired(tail_len))
                begin
                    seq_pending = BUTTON_NONE;
                    go_to(PH_IDLE);
                end
            end
            default:
            begin
                seq_pending = BUTTON_NONE;
                go_to(PH_IDLE);
            end
        endcase

        pins.supply_on   = seq_supply;
        pins.reset_drive = (seq_phase == PH_START) || (seq_phase == PH_PG_WAIT) ||
                           (seq_phase == PH_RST_HOLD) || (seq_phase == PH_PG_LOST) ||
                           (seq_phase == PH_RST_TAIL) ||
                           (((seq_phase == PH_DEB1) || (seq_phase == PH_WAIT_REL)) &&
                            (seq_pending == BUTTON_RESET));
        pins.nmi_drive   = (seq_phase == PH_NMI);
        pins.busy_res    = (seq_phase != PH_IDLE);
        pins.reply_valid = answered;
        pins.power_state = answered & seq_supply;
        return pins;
    endfunction

    // ------------------------------------------------------------------------------------
    // Result side: ready pacing and the checker.
    // ------------------------------------------------------------------------------------
    // Ready changes on the falling edge. A hold-off, when asked for, keeps it low until its
    // counter runs out; otherwise it drops at random while pacing is on.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_ready <= 1'b0;
                hold_off_left--;
            end
            else if (recv_idles && $urandom_range(99) < IDLE_PERCENT)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_pin(input string pin_name, input logic seen, input logic wanted);
        if (seen !== wanted)
            report_mismatch($sformatf("beat %0d %s is %b, expected %b",
                                      pins_checked, pin_name, seen, wanted));
    endtask

    // Every accepted result beat is matched against the oldest pending prediction.
    always @(posedge clk)
    begin : check_results
        result_t wanted;
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                input_stall_cycles++;
            if (out_valid && out_ready)
            begin
                if (pins_due.size() == 0)
                    report_mismatch("result beat arrived with no tick waiting for it");
                else
                begin
                    wanted = pins_due.pop_front();
                    check_pin("supply_on",   supply_on,   wanted.supply_on);
                    check_pin("reset_drive", reset_drive, wanted.reset_drive);
                    check_pin("nmi_drive",   nmi_drive,   wanted.nmi_drive);
                    check_pin("busy_res",    busy_res,    wanted.busy_res);
                    check_pin("reply_valid", reply_valid, wanted.reply_valid);
                    check_pin("power_state", power_state, wanted.power_state);
                end
                pins_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Tick side: the shared driver tasks. Every task starts and ends on a falling edge.
    // ------------------------------------------------------------------------------------
    function automatic item_t tick_of(input logic [2:0] c, input logic pg, input logic rl,
                                      input logic pb, input logic rb, input logic db);
        item_t t;
        t.cmd            = c;
        t.power_good     = pg;
        t.reset_line_low = rl;
        t.power_button   = pb;
        t.reset_button   = rb;
        t.debug_button   = db;
        return t;
    endfunction

    function automatic item_t quiet_tick();
        return tick_of(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    endfunction

    // Offers one tick beat, optionally after random idle cycles, and waits until it is taken.
    // The prediction is made at acceptance, so it always sees the state the block sees.
    task automatic send_tick(input item_t t);
        result_t pins;
        while (send_idles && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= t.cmd;
        power_good     <= t.power_good;
        reset_line_low <= t.reset_line_low;
        power_button   <= t.power_button;
        reset_button   <= t.reset_button;
        debug_button   <= t.debug_button;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pins = predict_pins(t);
        pins_due.push_back(pins);
        ticks_sent++;
        if (pins.reply_valid)
            queries_seen++;
        @(negedge clk);
    endtask

    // Drops valid and waits until every predicted beat has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pins_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Quiet ticks let any running sequence finish; released buttons and good power mean
    // every phase ends in idle.
    task automatic run_until_idle();
        held_power = 1'b0;
        held_reset = 1'b0;
        held_debug = 1'b0;
        pg_level   = 1'b1;
        while (seq_phase != PH_IDLE)
            send_tick(quiet_tick());
    endtask

    // Drains, and then writes all three lengths in whatever phase the sequencer is in. A
    // fourth write goes to the unused index, which must change nothing.
    task automatic write_lengths(input logic [CFG_W-1:0] hold_len,
                                 input logic [CFG_W-1:0] pulse_len,
                                 input logic [CFG_W-1:0] settle_len);
        wait_drain();
        write_en    <= 1'b1;
        write_index <= REG_RESET_TICKS;
        write_data  <= hold_len;
        @(negedge clk);
        write_index <= REG_NMI_TICKS;
        write_data  <= pulse_len;
        @(negedge clk);
        write_index <= REG_DEBOUNCE_TICKS;
        write_data  <= settle_len;
        @(negedge clk);
        write_index <= REG_SPARE;
        write_data  <= CFG_W'($urandom);
        @(negedge clk);
        write_en <= 1'b0;
        reg_reset_len    = hold_len;
        reg_nmi_len      = pulse_len;
        reg_debounce_len = settle_len;
        settings_used++;
    endtask

    // Brings the sequencer to idle first, then writes the lengths.
    task automatic set_lengths(input logic [CFG_W-1:0] hold_len,
                               input logic [CFG_W-1:0] pulse_len,
                               input logic [CFG_W-1:0] settle_len);
        run_until_idle();
        write_lengths(hold_len, pulse_len, settle_len);
    endtask

    // Holds a button tick until the sequencer waits for release, keeps it pressed two more
    // ticks, then lets go and lets the sequence finish.
    task automatic press_and_release(input item_t pressed);
        send_tick(pressed);
        while (seq_phase != PH_WAIT_REL)
            send_tick(pressed);
        repeat (2)
            send_tick(pressed);
        run_until_idle();
    endtask

    // Random tick with persistent button and power-good levels; a few are raw noise.
    function automatic item_t random_tick();
        item_t t;
        held_power = held_power ? ($urandom_range(99) >= 25) : ($urandom_range(99) < 4);
        held_reset = held_reset ? ($urandom_range(99) >= 25) : ($urandom_range(99) < 4);
        held_debug = held_debug ? ($urandom_range(99) >= 25) : ($urandom_range(99) < 4);
        pg_level   = pg_level ? ($urandom_range(99) >= 3) : ($urandom_range(99) < 35);
        if ($urandom_range(99) < 70)
            t.cmd = CMD_NONE;
        else
            t.cmd = 3'($urandom_range(7, 1));
        t.power_good     = pg_level;
        t.reset_line_low = ($urandom_range(99) < 5);
        t.power_button   = held_power;
        t.reset_button   = held_reset;
        t.debug_button   = held_debug;
        if ($urandom_range(99) < 5)
            t = item_t'(8'($urandom));
        return t;
    endfunction

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------
    // Start-up with the reset-time lengths: reset stays asserted under the default hold, and
    // everything offered during it, commands and buttons alike, is dropped. The hold is then
    // shortened while start-up still runs, so start-up ends on the next tick. One NMI pulse
    // and one debug button press follow with the short lengths.
    // Pacing stays off here, which is the long stretch without any idle cycles.
    task automatic test_startup_defaults();
        send_idles = 1'b0;
        recv_idles = 1'b0;
        repeat (STARTUP_TICKS)
            send_tick(item_t'(8'($urandom)));
        write_lengths(4, 3, 2);
        while (seq_phase == PH_START)
            send_tick(item_t'(8'($urandom)));
        send_tick(tick_of(CMD_NMI, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_idles = 1'b1;
        recv_idles = 1'b1;
    endtask

    // Every bus command, including the redundant ones, the spare codes and commands that
    // arrive while a sequence is running.
    task automatic test_commands();
        set_lengths(3, 2, 2);
        send_tick(tick_of(CMD_QUERY,       1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_SPARE_LO,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_SPARE_HI,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_POWER_OFF,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        // Power on without power-good: reset holds until the supply reports good.
        send_tick(tick_of(CMD_POWER_ON,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_QUERY,       1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_RESET_PULSE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_POWER_OFF,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_NONE,        1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_QUERY,       1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        // A second power on with the supply already up changes nothing.
        send_tick(tick_of(CMD_POWER_ON,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_QUERY,       1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_RESET_PULSE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_NMI,         1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        send_tick(tick_of(CMD_NMI,         1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        // A command beats every pin event raised on the same tick.
        send_tick(tick_of(CMD_QUERY,       1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(tick_of(CMD_POWER_OFF,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_QUERY,       1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // Pin events in priority order: external reset, power, reset and debug buttons, and
    // loss of power-good, each with the lower ones raised at the same time.
    task automatic test_pin_priority();
        set_lengths(3, 2, 2);
        send_tick(tick_of(CMD_POWER_ON, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        send_tick(tick_of(CMD_NONE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        run_until_idle();
        // Power button with the supply on switches it off and waits for release.
        press_and_release(tick_of(CMD_NONE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        // With the supply off an external reset is ignored and the reset button wins.
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        // Power button with the supply off runs the whole power-on sequence first.
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        press_and_release(tick_of(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        repeat (3)
            send_tick(tick_of(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        // Reset time well above debounce: the tail after release is the difference.
        set_lengths(6, 2, 2);
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    endtask

    // Zero in every length register acts as a single tick; equal reset and debounce times
    // leave a one-tick tail.
    task automatic test_zero_lengths();
        set_lengths(0, 0, 0);
        send_tick(tick_of(CMD_RESET_PULSE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_NMI,         1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        send_tick(tick_of(CMD_NMI,         1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    endtask

    // Each register at its largest value in turn. Only sequences that do not use the long
    // register run meanwhile, so the register is stored but no million-tick phase starts.
    task automatic test_extreme_lengths();
        set_lengths(3, 2, 2);
        send_tick(tick_of(CMD_POWER_OFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        set_lengths(LEN_MAX, 1, 1);
        send_tick(tick_of(CMD_QUERY,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_NMI,      1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(tick_of(CMD_NONE,     1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(CMD_SPARE_HI, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

        set_lengths(2, LEN_MAX, 1);
        send_tick(tick_of(CMD_POWER_ON,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        send_tick(tick_of(CMD_RESET_PULSE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        press_and_release(tick_of(CMD_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));

        set_lengths(3, 2, LEN_MAX);
        send_tick(tick_of(CMD_POWER_ON, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        send_tick(tick_of(CMD_NMI,      1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        send_tick(tick_of(CMD_NONE,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        run_until_idle();
        send_tick(tick_of(CMD_QUERY,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // The result side holds off for a long counted stretch while ticks keep coming, so the
    // block fills up and has to stall its input.
    task automatic test_result_backpressure();
        set_lengths(4, 3, 2);
        hold_off_left = 300;
        repeat (60)
            send_tick(random_tick());
        wait_drain();
    endtask

    // Random traffic under several length settings, from the shortest up to a random mix.
    task automatic test_random_traffic();
        for (int round = 0; round < 7; round++)
        begin
            case (round)
                0:       set_lengths(1, 1, 1);
                1:       set_lengths(0, 0, 0);
                2:       set_lengths(8, 5, 3);
                3:       set_lengths(3, 4, 7);
                4:       set_lengths(5, 5, 5);
                5:       set_lengths(2, 1, 1);
                default: set_lengths(CFG_W'($urandom_range(16, 1)),
                                     CFG_W'($urandom_range(16, 1)),
                                     CFG_W'($urandom_range(16, 1)));
            endcase
            repeat (180)
                send_tick(random_tick());
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        write_en       = 1'b0;
        write_index    = '0;
        write_data     = '0;
        in_valid       = 1'b0;
        cmd            = CMD_NONE;
        power_good     = 1'b0;
        reset_line_low = 1'b0;
        power_button   = 1'b0;
        reset_button   = 1'b0;
        debug_button   = 1'b0;

        // The predicted block comes out of reset like the real one.
        reg_reset_len    = RESET_TICKS_DEFAULT;
        reg_nmi_len      = NMI_TICKS_DEFAULT;
        reg_debounce_len = DEBOUNCE_TICKS_DEFAULT;
        seq_phase        = PH_START;
        seq_timer        = '0;
        seq_supply       = 1'b0;
        seq_pending      = BUTTON_NONE;
        held_power       = 1'b0;
        held_reset       = 1'b0;
        held_debug       = 1'b0;
        pg_level         = 1'b1;
        send_idles       = 1'b0;
        recv_idles       = 1'b0;
        hold_off_left    = 0;

        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;

        test_startup_defaults();
        test_commands();
        test_pin_priority();
        test_zero_lengths();
        test_extreme_lengths();
        test_result_backpressure();
        test_random_traffic();
        wait_drain();

        $display("Run covered %0d tick beats with %0d power queries over %0d length settings,",
                 ticks_sent, queries_seen, settings_used);
        $display("zero and full-scale lengths included; %0d result beats checked, %0d input stalls.",
                 pins_checked, input_stall_cycles);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
